@@ src/pcu_pkg.sv @@
`timescale 1ns / 1ps
// Package for the Pearson correlation unit: sizes, codes and the
// controller-to-datapath command and status structs. No dependencies.
package pcu_pkg;

    localparam int MAX_PAIRS   = 4096;
    localparam int SAMPLE_BITS = 16;

    localparam int IN_W     = 16;                        // input field width
    localparam int Q_W      = 16;                        // Q1.15 result width
    localparam int STATUS_W = 2;
    localparam int CNT_W    = $clog2(MAX_PAIRS + 1);     // pair count
    localparam int GROW_W   = $clog2(MAX_PAIRS);         // growth of the sums
    localparam int SUM_W    = SAMPLE_BITS + GROW_W;      // signed sum of samples
    localparam int SQ_W     = 2 * SAMPLE_BITS - 1 + GROW_W; // unsigned sum of squares
    localparam int XY_W     = SQ_W + 1;                  // signed sum of products
    localparam int OP_W     = CNT_W + SQ_W;              // multiplier operand
    localparam int PROD_W   = 2 * OP_W;                  // multiplier product
    localparam int C_W      = OP_W + 2;                  // signed covariance term
    localparam int CMP_W    = PROD_W + 2 * Q_W;          // root search compare
    localparam int ROOT_SH  = 2 * Q_W - 2;               // scale of c*c by 2^30
    localparam int MCNT_W   = $clog2(OP_W);
    localparam int BIT_W    = $clog2(Q_W);

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_VAR = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd2;

    // Multiplication steps of the final computation, in issue order.
    typedef enum logic [2:0] {
        OP_N_SXX  = 3'd0,
        OP_SX_SX  = 3'd1,
        OP_N_SYY  = 3'd2,
        OP_SY_SY  = 3'd3,
        OP_N_SXY  = 3'd4,
        OP_SX_SY  = 3'd5,
        OP_VX_VY  = 3'd6,
        OP_C_C    = 3'd7
    } t_op;

    typedef struct packed {
        logic accum;
        logic mul_start;
        logic mul_step;
        logic mul_store;
        t_op  op;
        logic root_init;
        logic root_step;
        logic load_out;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic root_done;
    } t_stat;

endpackage

@@ src/pcu_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the Pearson correlation unit: running sums, a shared
// shift-add multiplier, the digit-by-digit root search and the result register.
// Depends on pcu_pkg.
module pcu_datapath (
    input  logic                              i_clk,
    input  pcu_pkg::t_cmd                     i_cmd,
    input  logic [pcu_pkg::IN_W-1:0]          i_model,
    input  logic [pcu_pkg::IN_W-1:0]          i_data,
    output pcu_pkg::t_stat                    o_stat,
    output logic [pcu_pkg::Q_W-1:0]           o_corr,
    output logic [pcu_pkg::STATUS_W-1:0]      o_status,
    input  logic                              i_rst_n
);

    localparam int OP_W   = pcu_pkg::OP_W;
    localparam int PROD_W = pcu_pkg::PROD_W;
    localparam int CMP_W  = pcu_pkg::CMP_W;
    localparam int C_W    = pcu_pkg::C_W;
    localparam int Q_W    = pcu_pkg::Q_W;

    // Running state.
    logic [pcu_pkg::CNT_W-1:0]        r_cnt;
    logic signed [pcu_pkg::SUM_W-1:0] r_sx, r_sy;
    logic [pcu_pkg::SQ_W-1:0]         r_sxx, r_syy;
    logic signed [pcu_pkg::XY_W-1:0]  r_sxy;
    logic                             r_ovf;

    // Multiplier and intermediate terms.
    logic [PROD_W-1:0]  r_ma, r_prod;
    logic [OP_W-1:0]    r_mb;
    logic [pcu_pkg::MCNT_W-1:0] r_mcnt;
    logic [OP_W-1:0]    r_pa, r_vx, r_vy, r_cmag;
    logic               r_neg;
    logic [PROD_W-1:0]  r_p;
    logic [CMP_W-1:0]   r_r;

    // Root search.
    logic [CMP_W-1:0]   r_a, r_bs, r_ps;
    logic [Q_W-1:0]     r_q;
    logic [pcu_pkg::BIT_W-1:0] r_bit;

    logic [Q_W-1:0]              r_corr;
    logic [pcu_pkg::STATUS_W-1:0] r_status;

    logic signed [pcu_pkg::SAMPLE_BITS-1:0]   x, y;
    logic signed [2*pcu_pkg::SAMPLE_BITS-1:0] xx, yy, xy;
    logic [pcu_pkg::SUM_W-1:0] sx_mag, sy_mag;
    logic [pcu_pkg::XY_W-1:0]  sxy_mag;
    logic [OP_W-1:0]           op_a, op_b;
    logic signed [C_W-1:0]     t1, t2, c_val;
    logic [CMP_W-1:0]          trial;
    logic                      take;
    logic [Q_W-1:0]            q_clip;

    assign x  = i_model[pcu_pkg::SAMPLE_BITS-1:0];
    assign y  = i_data[pcu_pkg::SAMPLE_BITS-1:0];
    assign xx = x * x;
    assign yy = y * y;
    assign xy = x * y;

    assign sx_mag  = r_sx[pcu_pkg::SUM_W-1]  ? pcu_pkg::SUM_W'(-r_sx)  : r_sx;
    assign sy_mag  = r_sy[pcu_pkg::SUM_W-1]  ? pcu_pkg::SUM_W'(-r_sy)  : r_sy;
    assign sxy_mag = r_sxy[pcu_pkg::XY_W-1]  ? pcu_pkg::XY_W'(-r_sxy)  : r_sxy;

    always_comb begin
        unique case (i_cmd.op)
            pcu_pkg::OP_N_SXX: begin op_a = OP_W'(r_cnt);  op_b = OP_W'(r_sxx);   end
            pcu_pkg::OP_SX_SX: begin op_a = OP_W'(sx_mag); op_b = OP_W'(sx_mag);  end
            pcu_pkg::OP_N_SYY: begin op_a = OP_W'(r_cnt);  op_b = OP_W'(r_syy);   end
            pcu_pkg::OP_SY_SY: begin op_a = OP_W'(sy_mag); op_b = OP_W'(sy_mag);  end
            pcu_pkg::OP_N_SXY: begin op_a = OP_W'(r_cnt);  op_b = OP_W'(sxy_mag); end
            pcu_pkg::OP_SX_SY: begin op_a = OP_W'(sx_mag); op_b = OP_W'(sy_mag);  end
            pcu_pkg::OP_VX_VY: begin op_a = r_vx;          op_b = r_vy;           end
            pcu_pkg::OP_C_C:   begin op_a = r_cmag;        op_b = r_cmag;         end
            default:           begin op_a = '0;            op_b = '0;             end
        endcase
    end

    // Covariance term: n*Sxy - Sx*Sy with both products held as magnitudes.
    assign t1    = r_sxy[pcu_pkg::XY_W-1] ? -$signed(C_W'(r_pa)) : $signed(C_W'(r_pa));
    assign t2    = (r_sx[pcu_pkg::SUM_W-1] ^ r_sy[pcu_pkg::SUM_W-1])
                 ? -$signed(C_W'(r_prod[OP_W-1:0])) : $signed(C_W'(r_prod[OP_W-1:0]));
    assign c_val = t1 - t2;

    // One root digit: (q + 2^b)^2 * P against c^2 * 2^30, kept incrementally.
    assign trial = r_a + r_bs + r_ps;
    assign take  = (trial <= r_r);

    assign o_stat.mul_done  = (r_mcnt == pcu_pkg::MCNT_W'(OP_W - 1));
    assign o_stat.root_done = (r_bit == '0);

    always_comb begin
        q_clip = r_q;
        if (r_q > 16'd32768) q_clip = 16'd32768;
        if (!r_neg && (q_clip > 16'd32767)) q_clip = 16'd32767;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_cnt <= '0;
            r_sx  <= '0;
            r_sy  <= '0;
            r_sxx <= '0;
            r_syy <= '0;
            r_sxy <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.accum) begin
            if (r_cnt >= pcu_pkg::CNT_W'(pcu_pkg::MAX_PAIRS)) begin
                r_ovf <= 1'b1;
            end else begin
                r_cnt <= r_cnt + 1'b1;
                r_sx  <= r_sx + pcu_pkg::SUM_W'(x);
                r_sy  <= r_sy + pcu_pkg::SUM_W'(y);
                r_sxx <= r_sxx + pcu_pkg::SQ_W'($unsigned(xx));
                r_syy <= r_syy + pcu_pkg::SQ_W'($unsigned(yy));
                r_sxy <= r_sxy + pcu_pkg::XY_W'(xy);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_ma   <= PROD_W'(op_a);
            r_mb   <= op_b;
            r_prod <= '0;
            r_mcnt <= '0;
        end else if (i_cmd.mul_step) begin
            r_prod <= r_prod + (r_mb[0] ? r_ma : '0);
            r_ma   <= r_ma << 1;
            r_mb   <= r_mb >> 1;
            r_mcnt <= r_mcnt + 1'b1;
        end

        if (i_cmd.mul_store) begin
            unique case (i_cmd.op)
                pcu_pkg::OP_N_SXX, pcu_pkg::OP_N_SYY, pcu_pkg::OP_N_SXY:
                    r_pa <= r_prod[OP_W-1:0];
                pcu_pkg::OP_SX_SX: r_vx <= r_pa - r_prod[OP_W-1:0];
                pcu_pkg::OP_SY_SY: r_vy <= r_pa - r_prod[OP_W-1:0];
                pcu_pkg::OP_SX_SY: begin
                    r_neg  <= c_val[C_W-1];
                    r_cmag <= c_val[C_W-1] ? OP_W'(-c_val) : OP_W'(c_val);
                end
                pcu_pkg::OP_VX_VY: r_p <= r_prod;
                pcu_pkg::OP_C_C:   r_r <= CMP_W'(r_prod) << pcu_pkg::ROOT_SH;
                default:           r_pa <= r_pa;
            endcase
        end

        if (i_cmd.root_init) begin
            r_a   <= '0;
            r_bs  <= '0;
            r_ps  <= CMP_W'(r_p) << pcu_pkg::ROOT_SH;
            r_q   <= '0;
            r_bit <= pcu_pkg::BIT_W'(Q_W - 1);
        end else if (i_cmd.root_step) begin
            if (take) begin
                r_a <= trial;
                r_q[r_bit] <= 1'b1;
            end
            r_bs  <= (r_bs >> 1) + (take ? r_ps : '0);
            r_ps  <= r_ps >> 2;
            r_bit <= r_bit - 1'b1;
        end

        if (i_cmd.load_out) begin
            if ((r_vx == '0) || (r_vy == '0)) begin
                r_corr   <= '0;
                r_status <= pcu_pkg::ST_ZERO_VAR;
            end else begin
                r_corr   <= r_neg ? Q_W'(-q_clip) : q_clip;
                r_status <= pcu_pkg::ST_OK;
            end
            if (r_ovf) r_status <= pcu_pkg::ST_DROPPED;
        end
    end

    assign o_corr   = r_corr;
    assign o_status = r_status;

endmodule

@@ src/pcu_ctrl.sv @@
`timescale 1ns / 1ps
// Controller of the Pearson correlation unit: sequences accumulation,
// the eight multiplications, the root search and the result beat. Depends on pcu_pkg.
module pcu_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_last,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  pcu_pkg::t_stat i_stat,
    output pcu_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_ACC,
        S_MUL_LOAD,
        S_MUL_RUN,
        S_MUL_STORE,
        S_ROOT_INIT,
        S_ROOT,
        S_OUT
    } t_state;

    t_state        r_state;
    pcu_pkg::t_op  r_op;
    logic          r_out_valid;
    logic          space;

    assign space       = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_ACC);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd           = '0;
        o_cmd.op        = r_op;
        o_cmd.accum     = (r_state == S_ACC) && i_in_valid;
        o_cmd.mul_start = (r_state == S_MUL_LOAD);
        o_cmd.mul_step  = (r_state == S_MUL_RUN);
        o_cmd.mul_store = (r_state == S_MUL_STORE);
        o_cmd.root_init = (r_state == S_ROOT_INIT);
        o_cmd.root_step = (r_state == S_ROOT);
        o_cmd.load_out  = (r_state == S_OUT) && space;
        o_cmd.clear     = o_cmd.load_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_op        <= pcu_pkg::OP_N_SXX;
            r_out_valid <= 1'b0;
        end else begin
            // A new result refills the register in the cycle the old one leaves.
            if ((r_state == S_OUT) && space) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_ACC: begin
                    if (i_in_valid && i_in_last) begin
                        r_op    <= pcu_pkg::OP_N_SXX;
                        r_state <= S_MUL_LOAD;
                    end
                end
                S_MUL_LOAD:  r_state <= S_MUL_RUN;
                S_MUL_RUN:   if (i_stat.mul_done) r_state <= S_MUL_STORE;
                S_MUL_STORE: begin
                    if (r_op == pcu_pkg::OP_C_C) begin
                        r_state <= S_ROOT_INIT;
                    end else begin
                        r_op    <= pcu_pkg::t_op'(r_op + 3'd1);
                        r_state <= S_MUL_LOAD;
                    end
                end
                S_ROOT_INIT: r_state <= S_ROOT;
                S_ROOT:      if (i_stat.root_done) r_state <= S_OUT;
                S_OUT: begin
                    if (space) r_state <= S_ACC;
                end
                default:     r_state <= S_ACC;
            endcase
        end
    end

    a_ready_only_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_ACC) |-> !o_cmd.accum)
        else $error("accumulation outside the accumulate state");
    a_load_has_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while full");
    a_last_starts_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accum && i_in_last) |=> (r_state == S_MUL_LOAD))
        else $error("last beat did not start the final computation");
    a_root_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.root_init |-> $past(o_cmd.mul_store))
        else $error("root search started without its operands");

endmodule

@@ src/pearson_correlation_unit.sv @@
`timescale 1ns / 1ps
// Sequence: a beat without tlast is summed in its cycle; after the tlast beat the shared serial
// multiplier forms the eight products, then the root search runs; the result loads once the output is free.
// Throughput: one pair per cycle while accumulating; s_axis_tready is low during the final pass.
// Reset (i_rst_n, synchronous, active low) clears the sums, the pair count and the result valid.
module pearson_correlation_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] model_sample, [31:16] data_sample
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [15:0] correlation, [17:16] status, rest zero
);

    // The controller owns the handshakes and the sequence of steps; the datapath
    // holds the sums, the multiplier, the root search and the result register.
    pcu_pkg::t_cmd  cmd;
    pcu_pkg::t_stat stat;
    logic [pcu_pkg::Q_W-1:0]      corr;
    logic [pcu_pkg::STATUS_W-1:0] status;

    pcu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pcu_datapath u_datapath (
        .i_clk    (i_clk),
        .i_cmd    (cmd),
        .i_model  (s_axis_tdata[15:0]),
        .i_data   (s_axis_tdata[31:16]),
        .o_stat   (stat),
        .o_corr   (corr),
        .o_status (status),
        .i_rst_n  (i_rst_n)
    );

    // The result beat: coefficient in the low half, status above it.
    assign m_axis_tdata = {6'd0, status, corr};

endmodule
